// ===== hdl/histogram_median_filter_assert.svh =====
// Assertion macros for the histogram median filter.
// Used by histogram_median_filter.sv; expects clk and rst_n in scope.
`ifndef HISTOGRAM_MEDIAN_FILTER_ASSERT_SVH
`define HISTOGRAM_MEDIAN_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define HMF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");
`define HMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");
`else
`define HMF_ASSERT_IMP(label, ante, cons)
`define HMF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/hmf_pkg.sv =====
// Shared types and constants of the histogram median filter.
// No dependencies; imported by histogram_median_filter.sv and the testbench.
package hmf_pkg;

    localparam int COORD_W = 9;
    localparam int PIX_W   = 8;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_FIN    = 4'b1000
    } state_t;

endpackage

// ===== hdl/histogram_median_filter.sv =====
// A load is written to the image memory when it is accepted. A query makes one pass over the
// clipped window for each result bit, where the result has the bit count of PIXEL_LEVELS-1.
// Throughput: one item at a time; the single read port of the image memory sets the pace,
// since every result bit costs one pass that reads the whole window once.
// Reset (rst_n, asynchronous, active low) clears control state only; the image memory
// holds no defined value until a pixel is written.
`include "histogram_median_filter_assert.svh"

module histogram_median_filter
    import hmf_pkg::*;
#(
    parameter int IMG_SIZE     = 512,
    parameter int WINDOW       = 5,
    parameter int PIXEL_LEVELS = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic [COORD_W-1:0] row,
    input  logic [COORD_W-1:0] col,
    input  logic [PIX_W-1:0]   pixel,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIX_W-1:0]   median_value
);

    // Coordinates must hold start + WINDOW before the clip at the image edge.
    localparam int CW    = $clog2(IMG_SIZE + WINDOW + 1);
    localparam int DEPTH = IMG_SIZE * IMG_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = $clog2(PIXEL_LEVELS);
    localparam int WCW   = $clog2(WINDOW + 1);
    localparam int CNTW  = $clog2(WINDOW * WINDOW + 1);
    localparam int HALF  = WINDOW / 2;

    // The median is found by radix selection, most significant bit first. Each pass
    // reads the whole window from the image memory and counts the pixels that still
    // match the result prefix and have a zero in the current bit. If the remaining rank
    // fits among them, the bit is zero; otherwise it is one and the rank drops by that
    // count. The rank starts at floor(window_count / 2), so a rank of zero gives zero.
    // The bit select is a shift register moving one bit per pass; the prefix mask gains that bit.

    state_t state_reg, state_next;

    logic [CW-1:0]   r_reg, r_next;
    logic [CW-1:0]   c_reg, c_next;
    logic [CW-1:0]   r0_reg, r0_next;
    logic [CW-1:0]   c0_reg, c0_next;
    logic [CW-1:0]   r_last_reg, r_last_next;
    logic [CW-1:0]   c_last_reg, c_last_next;
    logic [CNTW-1:0] k_reg, k_next;
    logic [CNTW-1:0] cnt0_reg, cnt0_next;
    logic [VW-1:0]   sel_reg, sel_next;
    logic [VW-1:0]   mask_reg, mask_next;
    logic [VW-1:0]   prefix_reg, prefix_next;
    logic            rd_vld_reg;
    logic            out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] median_reg, median_next;
    logic [PIX_W-1:0] rdata_reg;

    logic [PIX_W-1:0] mem [DEPTH];

    // Window bounds of an incoming query.
    logic [CW-1:0]    q_row, q_col;
    logic [CW-1:0]    q_r0, q_c0, q_r_end, q_c_end, q_r1, q_c1;
    logic [WCW-1:0]   q_rows, q_cols;
    logic [2*WCW-1:0] q_area;

    logic            in_fire;
    logic            mem_we, mem_re;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [VW-1:0]   pix_val;
    logic            cand, hit;
    logic [CNTW-1:0] cnt_sum;
    logic            scan_last;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    assign q_row = (32'(row) >= IMG_SIZE) ? CW'(IMG_SIZE - 1) : CW'(row);
    assign q_col = (32'(col) >= IMG_SIZE) ? CW'(IMG_SIZE - 1) : CW'(col);

    assign q_r0    = (q_row >= CW'(HALF)) ? q_row - CW'(HALF) : '0;
    assign q_c0    = (q_col >= CW'(HALF)) ? q_col - CW'(HALF) : '0;
    assign q_r_end = q_r0 + CW'(WINDOW);
    assign q_c_end = q_c0 + CW'(WINDOW);
    assign q_r1    = (q_r_end > CW'(IMG_SIZE)) ? CW'(IMG_SIZE) : q_r_end;
    assign q_c1    = (q_c_end > CW'(IMG_SIZE)) ? CW'(IMG_SIZE) : q_c_end;
    assign q_rows  = WCW'(q_r1 - q_r0);
    assign q_cols  = WCW'(q_c1 - q_c0);
    assign q_area  = (2*WCW)'(q_rows) * (2*WCW)'(q_cols);

    // Writes outside the image are dropped.
    assign mem_we  = in_fire && (mode == MODE_LOAD)
                     && (32'(row) < IMG_SIZE) && (32'(col) < IMG_SIZE);
    assign wr_addr = AW'(row) * AW'(IMG_SIZE) + AW'(col);
    assign mem_re  = (state_reg == ST_SCAN);
    assign rd_addr = AW'(r_reg) * AW'(IMG_SIZE) + AW'(c_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= pixel;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Stored values above the top level fall into the top bin.
    assign pix_val = (32'(rdata_reg) >= PIXEL_LEVELS) ? VW'(PIXEL_LEVELS - 1) : VW'(rdata_reg);
    assign cand    = ((pix_val ^ prefix_reg) & mask_reg) == '0;
    assign hit     = rd_vld_reg && cand && ((pix_val & sel_reg) == '0);
    assign cnt_sum = cnt0_reg + CNTW'(hit);

    assign scan_last = (r_reg == r_last_reg) && (c_reg == c_last_reg);

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        r0_next        = r0_reg;
        c0_next        = c0_reg;
        r_last_next    = r_last_reg;
        c_last_next    = c_last_reg;
        k_next         = k_reg;
        cnt0_next      = cnt0_reg;
        sel_next       = sel_reg;
        mask_next      = mask_reg;
        prefix_next    = prefix_reg;
        median_next    = median_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (mode == MODE_QUERY))
                begin
                    r_next      = q_r0;
                    c_next      = q_c0;
                    r0_next     = q_r0;
                    c0_next     = q_c0;
                    r_last_next = q_r1 - CW'(1);
                    c_last_next = q_c1 - CW'(1);
                    k_next      = CNTW'(q_area >> 1);
                    cnt0_next   = '0;
                    sel_next    = VW'(1) << (VW - 1);
                    mask_next   = '0;
                    prefix_next = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt0_next = cnt_sum;
                if (c_reg == c_last_reg)
                begin
                    c_next = c0_reg;
                    r_next = r_reg + CW'(1);
                end
                else
                begin
                    c_next = c_reg + CW'(1);
                end
                if (scan_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                // The last read of the pass lands here and is counted in cnt_sum.
                if (k_reg > cnt_sum)
                begin
                    k_next      = k_reg - cnt_sum;
                    prefix_next = prefix_reg | sel_reg;
                end
                if (sel_reg[0])
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    sel_next   = sel_reg >> 1;
                    mask_next  = mask_reg | sel_reg;
                    r_next     = r0_reg;
                    c_next     = c0_reg;
                    cnt0_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_FIN:
            begin
                // Wait here while an earlier result still sits in the output register.
                if (!out_valid_reg || out_ready)
                begin
                    median_next    = PIX_W'(prefix_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= mem_re;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        c_reg      <= c_next;
        r0_reg     <= r0_next;
        c0_reg     <= c0_next;
        r_last_reg <= r_last_next;
        c_last_reg <= c_last_next;
        k_reg      <= k_next;
        cnt0_reg   <= cnt0_next;
        sel_reg    <= sel_next;
        mask_reg   <= mask_next;
        prefix_reg <= prefix_next;
        median_reg <= median_next;
    end

    assign out_valid    = out_valid_reg;
    assign median_value = median_reg;

    // The decision cycle always sees the final read of its pass.
    `HMF_ASSERT_IMP(a_decide_has_read, state_reg == ST_DECIDE, rd_vld_reg)
    // A query goes straight into its first pass.
    `HMF_ASSERT_NEXT(a_query_starts_scan, in_fire && (mode == MODE_QUERY), state_reg == ST_SCAN)
    // The read iterators never leave the window.
    `HMF_ASSERT_IMP(a_scan_in_window, mem_re, (r_reg <= r_last_reg) && (c_reg <= c_last_reg))
    // A new result only ever comes from the final state.
    `HMF_ASSERT_IMP(a_result_from_fin, $rose(out_valid_reg), $past(state_reg == ST_FIN))

endmodule

// ===== sim/histogram_median_filter_test.sv =====
// Self-checking testbench for histogram_median_filter: pixel loads and median queries,
// with the expected medians worked out from a shadow copy of the image.
// Depends on hmf_pkg and the histogram_median_filter RTL only.
`timescale 1ns / 1ps

module histogram_median_filter_test;
    import hmf_pkg::*;

    localparam int IMG         = 512;
    localparam int WIN         = 5;
    localparam int HALF        = WIN / 2;
    localparam int LEVELS      = 256;
    localparam int ITEM_GOAL   = 650;
    localparam int LONG_HOLD   = 1500;
    // The drain allows for the time of one more query plus margin.
    localparam int DRAIN_CYCLES = 400;
    localparam int REPORT_LIMIT = 10;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic               mode         = MODE_LOAD;
    logic [COORD_W-1:0] row          = '0;
    logic [COORD_W-1:0] col          = '0;
    logic [PIX_W-1:0]   pixel        = '0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic [PIX_W-1:0]   median_value;

    // Shadow of the image store. A pixel is only part of a query window once it is written.
    logic [PIX_W-1:0] image_copy [IMG][IMG];
    bit               written    [IMG][IMG];

    logic [PIX_W-1:0] pending_medians [$];
    int unsigned      query_centers [$];
    int               items_sent = 0;
    int               mismatches = 0;

    // When quiet is set, neither side inserts gaps, which gives back-to-back stretches.
    bit               quiet = 1'b0;

    // Output side: random stalls, plus long hold-offs on request from a test task.
    int unsigned      holds_asked  = 0;
    int unsigned      holds_served = 0;
    int unsigned      hold_left    = 0;
    int unsigned      stall_left   = 0;
    int unsigned      rx_gap;

    histogram_median_filter #(
        .IMG_SIZE     (IMG),
        .WINDOW       (WIN),
        .PIXEL_LEVELS (LEVELS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .row          (row),
        .col          (col),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .median_value (median_value)
    );

    always #1 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned p;
        if (quiet)
            return 0;
        p = $urandom_range(99);
        if (p < 50)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Window span along one axis: starts WIN/2 before pos, clamped at 0,
    // and covers WIN positions clipped at the image edge (stop is exclusive).
    function automatic void span_of(input int pos, output int first, output int stop);
        first = (pos >= HALF) ? pos - HALF : 0;
        stop  = first + WIN;
        if (stop > IMG)
            stop = IMG;
    endfunction

    function automatic bit window_ready(input int r, input int c);
        int r0, r1, c0, c1;
        span_of(r, r0, r1);
        span_of(c, c0, c1);
        for (int rr = r0; rr < r1; rr++)
            for (int cc = c0; cc < c1; cc++)
                if (!written[rr][cc])
                    return 1'b0;
        return 1'b1;
    endfunction

    // Histogram of the window, then the smallest level whose running count
    // reaches half the window size, rounded down.
    function automatic logic [PIX_W-1:0] expected_median(input int r, input int c);
        int r0, r1, c0, c1, goal, running;
        int counts [LEVELS];
        span_of(r, r0, r1);
        span_of(c, c0, c1);
        foreach (counts[v])
            counts[v] = 0;
        for (int rr = r0; rr < r1; rr++)
            for (int cc = c0; cc < c1; cc++)
                counts[image_copy[rr][cc]]++;
        goal = ((r1 - r0) * (c1 - c0)) / 2;
        if (goal == 0)
            return '0;
        running = 0;
        for (int v = 0; v < LEVELS; v++)
        begin
            running += counts[v];
            if (running >= goal)
                return v[PIX_W-1:0];
        end
        return PIX_W'(LEVELS - 1);
    endfunction

    // Sends one beat and updates the shadow image or the expected medians once it is taken.
    // Valid is left high after acceptance so that a following beat can go out with no gap.
    task automatic send_item(input logic m, input int r, input int c, input int p);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        row      <= r[COORD_W-1:0];
        col      <= c[COORD_W-1:0];
        pixel    <= p[PIX_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (m == MODE_LOAD)
        begin
            image_copy[r][c] = p[PIX_W-1:0];
            written[r][c]    = 1'b1;
        end
        else
        begin
            pending_medians.push_back(expected_median(r, c));
        end
    endtask

    task automatic send_query(input int r, input int c);
        send_item(MODE_QUERY, r, c, $urandom_range(LEVELS - 1));
        query_centers.push_back(r * IMG + c);
    endtask

    // Output receiver. Each cycle it either serves a hold-off request, keeps stalling,
    // or decides afresh whether to accept.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD - 1;
            out_ready    <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            rx_gap = pick_gap();
            if (rx_gap != 0 && $urandom_range(2) == 0)
            begin
                stall_left <= rx_gap - 1;
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Result checker: every accepted beat is matched against the oldest expected median.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_medians.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected median beat: got %0d with nothing pending",
                             median_value);
            end
            else if (median_value !== pending_medians[0])
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("median mismatch: expected %0d, got %0d",
                             pending_medians[0], median_value);
                void'(pending_medians.pop_front());
            end
            else
            begin
                void'(pending_medians.pop_front());
            end
        end
    end

    // Bottom-right corner: the window shrinks to 3x3. Values include both extremes and
    // repeats, so the lower-median rule shows. The opposite corners see extreme loads.
    task automatic test_corner_values();
        int corner_vals [9] = '{255, 0, 128, 1, 254, 7, 7, 7, 200};
        for (int k = 0; k < 9; k++)
            send_item(MODE_LOAD, IMG - 3 + k / 3, IMG - 3 + k % 3, corner_vals[k]);
        send_item(MODE_QUERY, IMG - 1, IMG - 1, 255);
        query_centers.push_back((IMG - 1) * IMG + IMG - 1);
        send_item(MODE_LOAD, IMG - 3, IMG - 1, 0);
        send_item(MODE_LOAD, IMG - 2, IMG - 2, 0);
        send_item(MODE_LOAD, IMG - 1, IMG - 1, 0);
        send_item(MODE_QUERY, IMG - 1, IMG - 1, 0);
        send_item(MODE_LOAD, 0, 0, 255);
        send_item(MODE_LOAD, 0, IMG - 1, 0);
        send_item(MODE_LOAD, IMG - 1, 0, 255);
    endtask

    // The receiver holds off for a long stretch while queries and loads keep coming
    // back to back, so the block fills up and has to stall its input.
    task automatic test_output_backpressure();
        quiet = 1'b1;
        holds_asked++;
        for (int k = 0; k < 8; k++)
        begin
            if (k % 2 == 1)
                send_item(MODE_LOAD, $urandom_range(IMG - 3, IMG - 1),
                          $urandom_range(IMG - 3, IMG - 1), $urandom_range(LEVELS - 1));
            send_query(IMG - 1, IMG - 1);
        end
        quiet = 1'b0;
    endtask

    // Patch origin along one axis, biased toward the two image edges.
    function automatic int pick_origin(input int extent);
        int unsigned p;
        p = $urandom_range(9);
        if (p == 0)
            return 0;
        if (p == 1)
            return IMG - extent;
        return $urandom_range(IMG - extent);
    endfunction

    // Patch contents: uniform, clustered around one level (many ties), or that level mixed with extremes.
    function automatic int pick_value(input int style, input int centre);
        int v;
        case (style)
            0: v = $urandom_range(LEVELS - 1);
            1:
            begin
                v = centre + $urandom_range(6) - 3;
                if (v < 0)
                    v = 0;
                if (v > LEVELS - 1)
                    v = LEVELS - 1;
            end
            default: v = ($urandom_range(2) == 0) ? centre :
                         (($urandom_range(1) == 0) ? 0 : LEVELS - 1);
        endcase
        return v;
    endfunction

    // Random part. Most sequences write a fresh patch and query points whose windows
    // it covers; others rewrite part of a known window and query it again, or scatter
    // loads across the whole image and query a known centre again.
    task automatic test_random_patches();
        int unsigned kind, pick;
        int h, w, r0, c0, style, centre, r, c, s0, s1, t0, t1;
        bit found;
        while (items_sent < ITEM_GOAL)
        begin
            quiet = ($urandom_range(4) == 0);
            kind  = $urandom_range(99);
            if (kind < 60 || query_centers.size() == 0)
            begin
                h      = $urandom_range(WIN, WIN + 3);
                w      = $urandom_range(WIN, WIN + 3);
                r0     = pick_origin(h);
                c0     = pick_origin(w);
                style  = $urandom_range(2);
                centre = $urandom_range(LEVELS - 1);
                for (int rr = r0; rr < r0 + h; rr++)
                    for (int cc = c0; cc < c0 + w; cc++)
                        send_item(MODE_LOAD, rr, cc, pick_value(style, centre));
                repeat ($urandom_range(2, 5))
                begin
                    found = 1'b0;
                    for (int tries = 0; tries < 12 && !found; tries++)
                    begin
                        r     = $urandom_range(r0, r0 + h - 1);
                        c     = $urandom_range(c0, c0 + w - 1);
                        found = window_ready(r, c);
                    end
                    if (found)
                        send_query(r, c);
                end
            end
            else if (kind < 85)
            begin
                pick = query_centers[$urandom_range(query_centers.size() - 1)];
                r    = pick / IMG;
                c    = pick % IMG;
                span_of(r, s0, s1);
                span_of(c, t0, t1);
                repeat ($urandom_range(1, 4))
                    send_item(MODE_LOAD, $urandom_range(s0, s1 - 1),
                              $urandom_range(t0, t1 - 1), $urandom_range(LEVELS - 1));
                send_query(r, c);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_item(MODE_LOAD, $urandom_range(IMG - 1), $urandom_range(IMG - 1),
                              $urandom_range(LEVELS - 1));
                pick = query_centers[$urandom_range(query_centers.size() - 1)];
                send_query(pick / IMG, pick % IMG);
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_values();
        test_output_backpressure();
        test_random_patches();

        // Wait for every expected median, then give the block time to show stray beats.
        in_valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_medians.size() != 0)
            mismatches++;

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: stops the run far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
